// ===== sv/fcp_pkg.sv =====
// Shared types and constants for the FIR convolution peak block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fcp_pkg;

    localparam int MAX_TAPS   = 128;
    localparam int TAP_AW     = 7;    // address width of the tap stores
    localparam int TAPS_W     = 8;    // width of taps_in_use
    localparam int ACC_W      = 40;
    localparam int PROD_W     = 32;
    localparam int SAMPLE_W   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // raw func codes on the input stream
    localparam logic [1:0] FUNC_COEF    = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE  = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    typedef enum logic [1:0] {
        CMD_COEF,
        CMD_SAMPLE,
        CMD_RESTART
    } cmd_t;

    typedef struct packed {
        cmd_t                        cmd;
        logic [TAP_AW-1:0]           tap_index;
        logic signed [SAMPLE_W-1:0]  value;
    } cmd_item_t;

endpackage

// ===== sv/fir_convolution_peak.sv =====
// Top level of the FIR convolution peak block: taps register, front end,
// command queue and back end. Depends on fcp_pkg, fcp_front, fcp_queue, fcp_back.
`timescale 1ns / 1ps

// Direct-form FIR filter with a running peak of |output|. Requests on the
// input stream either load a coefficient, filter a sample or restart
// (clear history and peak). A sample request holds the back end for one
// multiply-accumulate per tap, min(taps_in_use, 128) taps, through the
// single multiplier, plus pop, pipeline drain and output load; with
// taps_in_use at 0 only pop, drain and load remain. It stays longer while
// the previous result has not been taken. Coefficient and restart
// requests complete as they are popped. A four-entry queue decouples the
// input from the back end, and the result register lets the next request
// start while a result waits to be taken. Unused func codes are accepted
// and dropped. taps_in_use resets to 1 and must be written only while idle.

module fir_convolution_peak
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata,     // taps_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // tap_index[6:0], value[22:7], zero pad
    input  logic [1:0]  s_tuser,       // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata        // filtered[39:0], peak[79:40]
);
    import fcp_pkg::*;

    logic [TAPS_W-1:0] taps_reg;
    logic              q_full;
    logic              q_push;
    cmd_item_t         push_item;
    logic              q_valid;
    cmd_item_t         q_item;
    logic              q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            taps_reg <= TAPS_W'(1);
        else if (cfg_wen)
            taps_reg <= cfg_wdata;
    end

    fcp_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    fcp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .valid     (q_valid),
        .item      (q_item),
        .pop       (q_pop)
    );

    fcp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .taps_in_use (taps_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== sv/fcp_front.sv =====
// Front end: takes requests off the input stream, decodes func and
// drops unused codes before they reach the queue. Depends on fcp_pkg.
`timescale 1ns / 1ps

module fcp_front
(
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,
    input  logic [1:0]                s_tuser,
    input  logic                      q_full,
    output logic                      q_push,
    output fcp_pkg::cmd_item_t        q_item
);
    import fcp_pkg::*;

    logic known;

    always_comb
    begin
        known       = 1'b1;
        q_item.cmd  = CMD_COEF;
        unique case (s_tuser)
            FUNC_COEF:    q_item.cmd = CMD_COEF;
            FUNC_SAMPLE:  q_item.cmd = CMD_SAMPLE;
            FUNC_RESTART: q_item.cmd = CMD_RESTART;
            default:      known      = 1'b0;
        endcase
        q_item.tap_index = s_tdata[TAP_AW-1:0];
        q_item.value     = s_tdata[TAP_AW+SAMPLE_W-1:TAP_AW];
    end

    // unused codes are swallowed without touching the queue
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready && known;

endmodule

// ===== sv/fcp_queue.sv =====
// Short command queue between front and back ends.
// Depends on fcp_pkg for the entry type and depth.
`timescale 1ns / 1ps

module fcp_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fcp_pkg::cmd_item_t  push_item,
    output logic                full,
    output logic                valid,
    output fcp_pkg::cmd_item_t  item,
    input  logic                pop
);
    import fcp_pkg::*;

    cmd_item_t           entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_pop;

    assign full   = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign valid  = (count_reg != '0);
    assign item   = entry_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== sv/fcp_back.sv =====
// Back end: coefficient store, sample ring, serial multiply-accumulate,
// peak tracking and the output register. Depends on fcp_pkg.
`timescale 1ns / 1ps

module fcp_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  fcp_pkg::cmd_item_t           q_item,
    output logic                         q_pop,
    input  logic [fcp_pkg::TAPS_W-1:0]   taps_in_use,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [79:0]                  m_tdata
);
    import fcp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FIN
    } state_t;

    state_t                       state_reg;
    logic [TAP_AW-1:0]            wp_reg;
    logic [TAPS_W-1:0]            fill_reg;
    logic [TAPS_W-1:0]            k_reg;
    logic [TAPS_W-1:0]            n_reg;
    logic [ACC_W-1:0]             peak_reg;
    logic                         out_valid_reg;
    logic signed [ACC_W-1:0]      out_filt_reg;
    logic [ACC_W-1:0]             out_peak_reg;

    logic signed [SAMPLE_W-1:0]   hist_mem [MAX_TAPS];
    logic signed [SAMPLE_W-1:0]   coef_mem [MAX_TAPS];

    logic signed [SAMPLE_W-1:0]   hist_rd_reg;
    logic signed [SAMPLE_W-1:0]   coef_rd_reg;
    logic                         rd_valid_reg;
    logic                         rd_zero_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic                         prod_valid_reg;
    logic signed [ACC_W-1:0]      acc_reg;

    logic                         start_sample;
    logic                         issue;
    logic [TAP_AW-1:0]            wp_next;
    logic [TAPS_W-1:0]            n_next;
    logic [ACC_W-1:0]             mag;
    logic [ACC_W-1:0]             peak_next;
    logic                         out_free;

    assign q_pop        = (state_reg == S_IDLE) && q_valid;
    assign start_sample = q_pop && (q_item.cmd == CMD_SAMPLE);
    assign issue        = (state_reg == S_RUN);
    assign wp_next      = wp_reg + 1'b1;
    assign n_next       = (taps_in_use > TAPS_W'(MAX_TAPS)) ? TAPS_W'(MAX_TAPS) : taps_in_use;
    assign mag          = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign peak_next    = (mag > peak_reg) ? mag : peak_reg;
    assign out_free     = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_peak_reg, out_filt_reg};

    // newest sample sits at wp_reg; history[k] lives at wp_reg - k
    always_ff @(posedge clk)
    begin
        if (start_sample)
            hist_mem[wp_next] <= q_item.value;
        if (q_pop && (q_item.cmd == CMD_COEF))
            coef_mem[q_item.tap_index] <= q_item.value;
        hist_rd_reg <= hist_mem[wp_reg - k_reg[TAP_AW-1:0]];
        coef_rd_reg <= coef_mem[k_reg[TAP_AW-1:0]];
        prod_reg    <= rd_zero_reg ? '0 : PROD_W'(hist_rd_reg * coef_rd_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            rd_zero_reg    <= 1'b0;
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            rd_valid_reg   <= issue;
            // entries older than the last restart read as zero
            rd_zero_reg    <= (k_reg >= fill_reg);
            prod_valid_reg <= rd_valid_reg;
            if (start_sample)
                acc_reg <= '0;
            else if (prod_valid_reg)
                acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_filt_reg  <= '0;
            out_peak_reg  <= '0;
        end
        else
        begin
            // in S_FIN the load below decides the output valid
            if (out_valid_reg && m_tready && (state_reg != S_FIN))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        unique case (q_item.cmd)
                            CMD_COEF:
                            begin
                            end
                            CMD_RESTART:
                            begin
                                fill_reg <= '0;
                                peak_reg <= '0;
                            end
                            CMD_SAMPLE:
                            begin
                                wp_reg <= wp_next;
                                if (fill_reg != TAPS_W'(MAX_TAPS))
                                    fill_reg <= fill_reg + 1'b1;
                                k_reg     <= '0;
                                n_reg     <= n_next;
                                state_reg <= (n_next == '0) ? S_DRAIN : S_RUN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_RUN:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg + 1'b1 == n_reg)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (!rd_valid_reg && !prod_valid_reg)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_filt_reg  <= acc_reg;
                        out_peak_reg  <= peak_next;
                        peak_reg      <= peak_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
